>>> hw/rtl/phr_pkg.sv
package phr_pkg;

    localparam logic [7:0]  FLAG_BYTE    = 8'h7e;
    localparam logic [7:0]  ESC_BYTE     = 8'h7d;
    localparam logic [7:0]  ESC_XOR      = 8'h20;
    localparam logic [7:0]  ADDR_BYTE    = 8'hff;
    localparam logic [7:0]  CTRL_ESCAPED = 8'h03 ^ ESC_XOR;
    localparam logic [15:0] FCS_POLY     = 16'h8408;
    localparam logic [15:0] PLAIN_SEED   = 16'hffff;
    localparam logic [15:0] AC_SEED      = 16'h3de3;
    localparam logic [15:0] GOOD_RESIDUE = 16'hf0b8;
    localparam logic [15:0] MAX_DEC_RST  = 16'd4096;
    localparam logic [2:0]  MIN_RAW_LEN  = 3'd5;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_START,
        ST_FF,
        ST_FF_ESC,
        ST_BODY
    } front_state_t;

    typedef enum logic [2:0] {
        CMD_BYTE,
        CMD_PRE1,
        CMD_PRE2,
        CMD_SEED,
        CMD_CLOSE
    } cmd_kind_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_INVALID  = 2'd1,
        STAT_BAD_FCS  = 2'd2,
        STAT_OVERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
        logic       short_frame;
    } cmd_t;

    typedef struct packed {
        logic [15:0] length;
        status_t     status;
        logic        last;
        logic [7:0]  data;
    } res_t;

    function automatic logic [15:0] fcs_update(input logic [15:0] fcs_in,
                                               input logic [7:0] b);
        logic [15:0] f;
        f = fcs_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            f = f[0] ? ((f >> 1) ^ FCS_POLY) : (f >> 1);
        end
        return f;
    endfunction

    localparam logic [15:0] FCS_AFTER_FF = fcs_update(PLAIN_SEED, ADDR_BYTE);

endpackage

>>> hw/rtl/phr_front.sv
module phr_front
    import phr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       queue_full,
    output logic       in_ready,
    output logic       cmd_push,
    output cmd_t       cmd
);

    front_state_t state_reg, state_next;
    logic [2:0]   raw_len_reg, raw_len_next;
    logic         accept;
    logic         is_flag;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign is_flag  = (in_byte == FLAG_BYTE);

    // next state
    always_comb begin
        state_next   = state_reg;
        raw_len_next = raw_len_reg;
        if (accept) begin
            if (state_reg == ST_HUNT) begin
                if (is_flag) begin
                    state_next   = ST_START;
                    raw_len_next = '0;
                end
            end else if (is_flag) begin
                state_next   = ST_START;
                raw_len_next = '0;
            end else begin
                if (raw_len_reg < MIN_RAW_LEN) begin
                    raw_len_next = raw_len_reg + 3'd1;
                end
                unique case (state_reg)
                    ST_START:  state_next = (in_byte == ADDR_BYTE) ? ST_FF : ST_BODY;
                    ST_FF:     state_next = (in_byte == ESC_BYTE) ? ST_FF_ESC : ST_BODY;
                    ST_FF_ESC: state_next = ST_BODY;
                    ST_BODY:   state_next = ST_BODY;
                    default:   state_next = ST_HUNT;
                endcase
            end
        end
    end

    // outputs
    always_comb begin
        cmd_push         = 1'b0;
        cmd.kind         = CMD_BYTE;
        cmd.data         = in_byte;
        cmd.short_frame  = (raw_len_reg < MIN_RAW_LEN);
        if (accept && state_reg != ST_HUNT) begin
            if (is_flag) begin
                cmd.kind = CMD_CLOSE;
                cmd_push = (raw_len_reg != 3'd0);
            end else begin
                unique case (state_reg)
                    ST_START: begin
                        cmd_push = (in_byte != ADDR_BYTE);
                    end
                    ST_FF: begin
                        cmd.kind = CMD_PRE1;
                        cmd_push = (in_byte != ESC_BYTE);
                    end
                    ST_FF_ESC: begin
                        cmd.kind = (in_byte == CTRL_ESCAPED) ? CMD_SEED : CMD_PRE2;
                        cmd_push = 1'b1;
                    end
                    ST_BODY: begin
                        cmd_push = 1'b1;
                    end
                    default: begin
                        cmd_push = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_HUNT;
            raw_len_reg <= '0;
        end else begin
            state_reg   <= state_next;
            raw_len_reg <= raw_len_next;
        end
    end

endmodule

>>> hw/rtl/phr_cmd_fifo.sv
module phr_cmd_fifo
    import phr_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg, count_next;

    assign full       = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("command pushed into full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && !head_valid))
        else $error("command popped from empty queue");

    a_ptr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (QUEUE_AW)'(wr_ptr_reg - rd_ptr_reg) == count_reg[QUEUE_AW-1:0])
        else $error("queue pointers disagree with fill count");

endmodule

>>> hw/rtl/phr_back.sv
module phr_back
    import phr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] max_decoded,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_ready,
    output logic        res_valid,
    input  logic        res_ready,
    output res_t        res
);

    logic        esc_reg, esc_next;
    status_t     err_reg, err_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [15:0] fcs_reg, fcs_next;
    logic [7:0]  d0_reg, d0_next;
    logic [7:0]  d1_reg, d1_next;
    logic        out_valid_reg;
    res_t        out_reg;

    logic        m_esc;
    status_t     m_err;
    logic [15:0] m_cnt;
    logic [15:0] m_fcs;
    logic [7:0]  m_d0;
    logic [7:0]  val;
    logic        take;
    logic        pop;
    logic        gen;
    res_t        gen_res;

    assign cmd_ready = !out_valid_reg || res_ready;
    assign pop       = cmd_valid && cmd_ready;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_comb begin
        m_esc = esc_reg;
        m_err = err_reg;
        m_cnt = cnt_reg;
        m_fcs = fcs_reg;
        m_d0  = d0_reg;
        // held prefix bytes land on a fresh frame: decode ff (and 7d) first
        if (cmd.kind == CMD_PRE1 || cmd.kind == CMD_PRE2) begin
            if (max_decoded == 16'd0) begin
                m_err = STAT_OVERFLOW;
            end else begin
                m_fcs = FCS_AFTER_FF;
                m_cnt = 16'd1;
                m_d0  = ADDR_BYTE;
                m_esc = (cmd.kind == CMD_PRE2);
            end
        end

        esc_next = m_esc;
        err_next = m_err;
        cnt_next = m_cnt;
        fcs_next = m_fcs;
        d0_next  = m_d0;
        d1_next  = d1_reg;
        val      = m_esc ? (cmd.data ^ ESC_XOR) : cmd.data;
        take     = m_esc || (cmd.data >= ESC_XOR);
        gen      = 1'b0;
        gen_res  = '{length: 16'd0, status: STAT_OK, last: 1'b0, data: 8'd0};

        unique case (cmd.kind) inside
            CMD_BYTE, CMD_PRE1, CMD_PRE2: begin
                if (m_err == STAT_OK) begin
                    if (cmd.data == ESC_BYTE) begin
                        if (m_esc) begin
                            err_next = STAT_INVALID;
                        end else begin
                            esc_next = 1'b1;
                        end
                    end else begin
                        esc_next = 1'b0;
                        if (take) begin
                            if (m_cnt >= max_decoded) begin
                                err_next = STAT_OVERFLOW;
                            end else begin
                                fcs_next = fcs_update(m_fcs, val);
                                cnt_next = m_cnt + 16'd1;
                                if (m_cnt >= 16'd2) begin
                                    gen          = 1'b1;
                                    gen_res.data = m_d0;
                                    d0_next      = d1_reg;
                                    d1_next      = val;
                                end else if (!m_cnt[0]) begin
                                    d0_next = val;
                                end else begin
                                    d1_next = val;
                                end
                            end
                        end
                    end
                end
            end
            CMD_SEED: begin
                fcs_next = AC_SEED;
            end
            CMD_CLOSE: begin
                gen          = 1'b1;
                gen_res.last = 1'b1;
                if (cmd.short_frame) begin
                    gen_res.status = STAT_INVALID;
                end else if (err_reg != STAT_OK) begin
                    gen_res.status = err_reg;
                end else if (esc_reg || cnt_reg < 16'd3) begin
                    gen_res.status = STAT_INVALID;
                end else if (fcs_reg != GOOD_RESIDUE) begin
                    gen_res.status = STAT_BAD_FCS;
                end else begin
                    gen_res.length = cnt_reg - 16'd2;
                end
                esc_next = 1'b0;
                err_next = STAT_OK;
                cnt_next = 16'd0;
                fcs_next = PLAIN_SEED;
            end
            default: begin
                gen = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            d0_reg <= d0_next;
            d1_reg <= d1_next;
        end
        if (pop && gen) begin
            out_reg <= gen_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_reg       <= 1'b0;
            err_reg       <= STAT_OK;
            cnt_reg       <= '0;
            fcs_reg       <= PLAIN_SEED;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                esc_reg <= esc_next;
                err_reg <= err_next;
                cnt_reg <= cnt_next;
                fcs_reg <= fcs_next;
            end
            if (pop && gen) begin
                out_valid_reg <= 1'b1;
            end else if (res_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> hw/rtl/ppp_hdlc_frame_receiver.sv
// PPP HDLC-like frame receiver with FCS-16 check. Raw line bytes enter on the s_ channel at up
// to one byte per cycle; decoded payload bytes and one end-of-frame status per non-empty frame
// leave on the m_ channel. Bytes before the first 0x7e flag are dropped; a leading ff 7d 23 is
// stripped and seeds the FCS with 0x3de3. The two FCS bytes are held back by a two-byte delay,
// so they never appear on the output. A status result has m_tlast high and m_tdata[7:0] zero;
// its length field holds the payload length only on an ok status. Payload bytes ahead of a
// status are valid payload only if that status is ok. Throughput is one line byte per cycle
// while the command queue is not full; the FCS update in the decode stage is combinational.
// The command behind a result enters the command queue at the accepting edge of its line
// byte; the result then loads the output register, which drives m_tvalid. A four-entry
// command queue sits between the framing front end and the decoder, so either side can stall
// without stalling the other. Write cfg_wdata (max_decoded) only while no frame is in flight.
module ppp_hdlc_frame_receiver
    import phr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [15:0] cfg_wdata,   // max_decoded
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] line_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [7:0] out_byte, [9:8] status, [25:10] out_length
    output logic        m_tlast      // is_status
);

    logic [15:0] max_decoded_reg;
    logic        queue_full;
    logic        cmd_push;
    cmd_t        push_cmd;
    logic        head_valid;
    cmd_t        head_cmd;
    logic        cmd_ready;
    res_t        res;

    // hold decoder capacity; reset to the default buffer size
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_decoded_reg <= MAX_DEC_RST;
        end else if (cfg_wen) begin
            max_decoded_reg <= cfg_wdata;
        end
    end

    // framing front end: hunt, prefix match, raw length, flag close
    phr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_byte    (s_tdata),
        .queue_full (queue_full),
        .in_ready   (s_tready),
        .cmd_push   (cmd_push),
        .cmd        (push_cmd)
    );

    // decouple front end from decoder
    phr_cmd_fifo u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (cmd_push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (head_valid && cmd_ready),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // decoder: unescape, FCS, delay line, status; owns the output register
    phr_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .max_decoded (max_decoded_reg),
        .cmd_valid   (head_valid),
        .cmd         (head_cmd),
        .cmd_ready   (cmd_ready),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res         (res)
    );

    // pack result: byte, status, length from the low bit up, zero fill to 32 bits
    assign m_tdata = {6'd0, res.length, res.status, res.data};
    assign m_tlast = res.last;

endmodule

>>> tb/tb_ppp_hdlc_frame_receiver.sv
`timescale 1ns / 100ps

module tb_ppp_hdlc_frame_receiver;
    import phr_pkg::*;

    // Cycles to let the command queue and output register empty after the last
    // expected result, and the number of cycles without any request before the
    // run is declared hung.
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 2000;

    // Prefix tracker stages of the frame front end.
    localparam logic [1:0] PFX_START  = 2'd0;
    localparam logic [1:0] PFX_FF     = 2'd1;
    localparam logic [1:0] PFX_FF_ESC = 2'd2;
    localparam logic [1:0] PFX_DONE   = 2'd3;

    typedef logic [7:0] octet_q_t [$];

    typedef enum {
        FLAW_DOUBLE_ESC,
        FLAW_TRAILING_ESC,
        FLAW_SHORT,
        FLAW_GARBAGE,
        FLAW_EMPTY
    } flaw_t;

    // One request on the result channel, split into its fields.
    typedef struct packed {
        logic [15:0] len;
        status_t     st;
        logic        last;
        logic [7:0]  data;
    } rx_result_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wen;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [7:0] line_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;     // [7:0] out_byte, [9:8] status, [25:10] out_length
    logic        m_tlast;     // is_status

    ppp_hdlc_frame_receiver dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Shadow copy of the receiver state, advanced once per accepted line byte.
    logic        fr_hunting;
    logic        fr_esc;
    logic        fr_ac_seen;
    logic [2:0]  fr_raw_len;
    logic [1:0]  fr_prefix;
    status_t     fr_error;
    logic [15:0] fr_count;
    logic [15:0] fr_fcs;
    logic [15:0] fr_capacity;
    logic [7:0]  fr_delay [2];

    rx_result_t  decoded_results [$];

    int  mismatches      = 0;
    int  line_bytes_sent = 0;
    bit  tx_burst        = 1'b0;
    bit  rx_burst        = 1'b0;

    // ------------------------------------------------------------------
    // Frame decoder prediction
    // ------------------------------------------------------------------

    // Serial form of the reflected CRC-16: one feedback bit per data bit.
    function automatic logic [15:0] fcs16_byte(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc;
        for (int k = 0; k < 8; k++) begin
            if (c[0] ^ b[k]) begin
                c = (c >> 1) ^ FCS_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // A flag clears everything but the hunt flag, the capacity and the delay line.
    task automatic clear_frame_state();
        fr_esc     = 1'b0;
        fr_ac_seen = 1'b0;
        fr_raw_len = '0;
        fr_prefix  = PFX_START;
        fr_error   = STAT_OK;
        fr_count   = '0;
        fr_fcs     = PLAIN_SEED;
    endtask

    task automatic reset_frame_model();
        fr_capacity = MAX_DEC_RST;
        fr_hunting  = 1'b1;
        fr_delay[0] = '0;
        fr_delay[1] = '0;
        clear_frame_state();
    endtask

    // Unescape, filter, count and checksum one byte; a byte leaves the delay
    // line once two newer ones sit behind it.
    task automatic decode_octet(input logic [7:0] raw, inout bit emitted,
                                inout logic [7:0] emit_byte);
        logic [7:0] b;
        b = raw;
        if (fr_error != STAT_OK) return;
        if (b == ESC_BYTE) begin
            if (fr_esc) begin
                fr_error = STAT_INVALID;
            end else begin
                fr_esc = 1'b1;
            end
            return;
        end
        if (fr_esc) begin
            b      = b ^ ESC_XOR;
            fr_esc = 1'b0;
        end else if (b < ESC_XOR) begin
            return;
        end
        if (fr_count >= fr_capacity) begin
            fr_error = STAT_OVERFLOW;
            return;
        end
        fr_fcs = fcs16_byte(fr_fcs, b);
        if (fr_count >= 16'd2) begin
            emitted     = 1'b1;
            emit_byte   = fr_delay[0];
            fr_delay[0] = fr_delay[1];
            fr_delay[1] = b;
        end else begin
            fr_delay[fr_count[0]] = b;
        end
        fr_count = fr_count + 16'd1;
    endtask

    task automatic frame_decoder_step(input logic [7:0] b);
        rx_result_t res;
        bit         emitted;
        logic [7:0] emit_byte;
        emitted   = 1'b0;
        emit_byte = '0;
        res       = '0;

        if (fr_hunting) begin
            if (b == FLAG_BYTE) begin
                fr_hunting = 1'b0;
                clear_frame_state();
            end
            return;
        end

        if (b == FLAG_BYTE) begin
            // Back-to-back flags close an empty frame with nothing to report.
            if (fr_raw_len == '0) return;
            res.last = 1'b1;
            if (fr_raw_len < MIN_RAW_LEN) begin
                res.st = STAT_INVALID;
            end else if (fr_error != STAT_OK) begin
                res.st = fr_error;
            end else if (fr_esc) begin
                res.st = STAT_INVALID;
            end else if (fr_count < 16'd3) begin
                res.st = STAT_INVALID;
            end else if (fr_fcs != GOOD_RESIDUE) begin
                res.st = STAT_BAD_FCS;
            end else begin
                res.st  = STAT_OK;
                res.len = fr_count - 16'd2;
            end
            decoded_results.push_back(res);
            clear_frame_state();
            return;
        end

        if (fr_raw_len < MIN_RAW_LEN) fr_raw_len = fr_raw_len + 3'd1;

        // On a prefix mismatch the held ff (and 7d) are decoded as plain data.
        case (fr_prefix)
            PFX_START: begin
                if (b == ADDR_BYTE) begin
                    fr_prefix = PFX_FF;
                end else begin
                    fr_prefix = PFX_DONE;
                    decode_octet(b, emitted, emit_byte);
                end
            end
            PFX_FF: begin
                if (b == ESC_BYTE) begin
                    fr_prefix = PFX_FF_ESC;
                end else begin
                    fr_prefix = PFX_DONE;
                    decode_octet(ADDR_BYTE, emitted, emit_byte);
                    decode_octet(b, emitted, emit_byte);
                end
            end
            PFX_FF_ESC: begin
                fr_prefix = PFX_DONE;
                if (b == CTRL_ESCAPED) begin
                    fr_ac_seen = 1'b1;
                    fr_fcs     = AC_SEED;
                end else begin
                    decode_octet(ADDR_BYTE, emitted, emit_byte);
                    decode_octet(ESC_BYTE, emitted, emit_byte);
                    decode_octet(b, emitted, emit_byte);
                end
            end
            default: begin
                decode_octet(b, emitted, emit_byte);
            end
        endcase

        if (emitted) begin
            res.data = emit_byte;
            decoded_results.push_back(res);
        end
    endtask

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH @%0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // Send one line byte as a request; keep tvalid high across back-to-back
    // requests so it never drops and rises in the same step.
    task automatic send_line_byte(input logic [7:0] b);
        int gap;
        if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (s_tready !== 1'b1);
        frame_decoder_step(b);
        line_bytes_sent++;
    endtask

    // Escape what must be escaped, plus the odd byte that need not be.
    task automatic send_encoded(input logic [7:0] b);
        if (b == FLAG_BYTE || b == ESC_BYTE || b < ESC_XOR || $urandom_range(0, 15) == 0) begin
            send_line_byte(ESC_BYTE);
            send_line_byte(b ^ ESC_XOR);
        end else begin
            send_line_byte(b);
        end
    endtask

    // Hold the sender until every predicted result is out, then let the
    // pipeline empty of bytes that produce nothing.
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (decoded_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_max_decoded(input logic [15:0] cap);
        hold_until_drained();
        cfg_wen     <= 1'b1;
        cfg_wdata   <= cap;
        fr_capacity  = cap;
        @(posedge aclk);
        cfg_wen <= 1'b0;
    endtask

    // Build a frame with its FCS (optionally corrupted), optional address/control
    // prefix, optional dropped control bytes, and close it with a flag.
    task automatic send_frame(input octet_q_t payload, input bit with_ac,
                              input bit bad_fcs, input bit noisy);
        octet_q_t    dec;
        logic [15:0] fcs;
        dec = payload;
        fcs = with_ac ? AC_SEED : PLAIN_SEED;
        foreach (payload[i]) fcs = fcs16_byte(fcs, payload[i]);
        fcs = ~fcs;
        if (bad_fcs) fcs = fcs ^ (16'h1 << $urandom_range(0, 15));
        dec.push_back(fcs[7:0]);
        dec.push_back(fcs[15:8]);
        if (with_ac) begin
            send_line_byte(ADDR_BYTE);
            send_line_byte(ESC_BYTE);
            send_line_byte(CTRL_ESCAPED);
        end
        foreach (dec[i]) begin
            if (noisy && $urandom_range(0, 7) == 0) send_line_byte(8'($urandom_range(0, 31)));
            send_encoded(dec[i]);
        end
        send_line_byte(FLAG_BYTE);
    endtask

    task automatic send_raw_frame(input octet_q_t body);
        foreach (body[i]) send_line_byte(body[i]);
        send_line_byte(FLAG_BYTE);
    endtask

    function automatic logic [7:0] random_body_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == FLAG_BYTE);
        return b;
    endfunction

    task automatic send_flawed_frame(input flaw_t kind);
        octet_q_t body;
        int       n;
        int       pos;
        case (kind)
            FLAW_SHORT: begin
                n = $urandom_range(1, 4);
            end
            FLAW_GARBAGE: begin
                n = $urandom_range(5, 20);
            end
            FLAW_DOUBLE_ESC: begin
                n = $urandom_range(2, 10);
            end
            FLAW_TRAILING_ESC: begin
                n = $urandom_range(4, 12);
            end
            default: begin
                repeat ($urandom_range(1, 3)) send_line_byte(FLAG_BYTE);
                return;
            end
        endcase
        repeat (n) body.push_back(random_body_byte());
        if (kind == FLAW_DOUBLE_ESC) begin
            pos = $urandom_range(0, n);
            body.insert(pos, ESC_BYTE);
            body.insert(pos, ESC_BYTE);
        end else if (kind == FLAW_TRAILING_ESC) begin
            body.push_back(ESC_BYTE);
        end
        send_raw_frame(body);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Drop noise before the first flag, then close an empty frame.
    task automatic test_hunt_and_empty();
        send_line_byte(8'h41);
        send_line_byte(ESC_BYTE);
        send_line_byte(8'h00);
        send_line_byte(FLAG_BYTE);
        send_line_byte(FLAG_BYTE);
    endtask

    // Prefixed frame with an all-zero byte; unprefixed frame whose leading
    // ff 7d 5e looks like a prefix but is not one.
    task automatic test_good_frames();
        send_frame('{8'h00}, 1'b1, 1'b0, 1'b0);
        send_frame('{8'hff, FLAG_BYTE}, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_flawed_frames();
        send_raw_frame('{8'h41});
        send_raw_frame('{8'h41, 8'h42, 8'h43, 8'h44, ESC_BYTE});
        send_raw_frame('{8'h41, ESC_BYTE, ESC_BYTE, 8'h42, 8'h43});
        // Five raw bytes, but the control bytes leave only two decoded.
        send_raw_frame('{8'h41, 8'h01, 8'h02, 8'h03, 8'h42});
        send_frame('{8'h10, 8'h20, 8'h30}, 1'b0, 1'b1, 1'b0);
    endtask

    task automatic test_capacity_limits();
        set_max_decoded(16'd0);
        send_frame('{8'h55}, 1'b1, 1'b0, 1'b0);
        set_max_decoded(16'd3);
        send_frame('{8'ha5}, 1'b0, 1'b0, 1'b0);
        send_frame('{8'ha5, 8'h5a}, 1'b0, 1'b0, 1'b0);
        set_max_decoded(16'hffff);
        send_frame('{8'h01, 8'h80, 8'hfe, 8'h7f, 8'h20, 8'h1f, 8'h5d, 8'hc3}, 1'b1, 1'b0, 1'b1);
        set_max_decoded(MAX_DEC_RST);
    endtask

    // Mostly well-formed frames with random content, the rest broken; with
    // small_capacity the limit is rewritten every few frames.
    task automatic test_random_traffic(input int budget, input bit small_capacity);
        octet_q_t payload;
        int       stop_at;
        int       pick;
        int       len;
        int       frames;
        stop_at = line_bytes_sent + budget;
        frames  = 0;
        while (line_bytes_sent < stop_at) begin
            if (small_capacity && frames % 8 == 0) begin
                set_max_decoded(16'($urandom_range(0, 24)));
            end else if ($urandom_range(0, 29) == 0) begin
                hold_until_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < 74) begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16);
                payload.delete();
                repeat (len) payload.push_back(8'($urandom_range(0, 255)));
                send_frame(payload, 1'($urandom_range(0, 1)), pick >= 66,
                           $urandom_range(0, 3) == 0);
            end else if (pick < 80) begin
                send_flawed_frame(FLAW_DOUBLE_ESC);
            end else if (pick < 86) begin
                send_flawed_frame(FLAW_TRAILING_ESC);
            end else if (pick < 91) begin
                send_flawed_frame(FLAW_SHORT);
            end else if (pick < 96) begin
                send_flawed_frame(FLAW_GARBAGE);
            end else begin
                send_flawed_frame(FLAW_EMPTY);
            end
            frames++;
        end
    endtask

    // ------------------------------------------------------------------
    // Result sink: draw a stall per result, then compare each accepted
    // request field by field against the oldest prediction.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int         hold;
        rx_result_t want;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
            hold = rx_burst ? 0 : $urandom_range(0, 14);
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            if (decoded_results.size() == 0) begin
                report_mismatch("result with nothing pending", m_tdata, 32'h0);
            end else begin
                want = decoded_results.pop_front();
                if (m_tdata[7:0] !== want.data)
                    report_mismatch("out_byte", 32'(m_tdata[7:0]), 32'(want.data));
                if (m_tlast !== want.last)
                    report_mismatch("is_status", 32'(m_tlast), 32'(want.last));
                if (m_tdata[9:8] !== want.st)
                    report_mismatch("status", 32'(m_tdata[9:8]), 32'(want.st));
                if (m_tdata[25:10] !== want.len)
                    report_mismatch("out_length", 32'(m_tdata[25:10]), 32'(want.len));
            end
        end
    end

    // Watchdog: end the run once no request moves on either side for too long.
    initial begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stalled = 0;
            end else begin
                stalled++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        aresetn   = 1'b0;
        cfg_wen   = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        reset_frame_model();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_hunt_and_empty();
        test_good_frames();
        test_flawed_frames();
        test_capacity_limits();
        test_random_traffic(900, 1'b0);
        set_max_decoded(16'hffff);
        test_random_traffic(500, 1'b0);
        test_random_traffic(600, 1'b1);

        hold_until_drained();
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
